// ----- rtl/drba_pkg.sv -----
// package for the descriptor ring with bump allocator
// ring geometry, command and status codes, controller command struct
`default_nettype none

package drba_pkg;

    localparam int RING_SLOTS = 64;
    localparam int IDX_W      = $clog2(RING_SLOTS);
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic       CMD_ENQ = 1'b0;
    localparam logic       CMD_DEQ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctrl;

endpackage

`default_nettype wire

// ----- rtl/drba_ctrl.sv -----
// controller state machine for the descriptor ring
// sequences capture, execute and response; uses drba_pkg
`default_nettype none

module drba_ctrl
    import drba_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_req_valid,
    output logic       o_req_ready,
    output logic       o_rsp_valid,
    input  wire logic  i_rsp_ready,
    output t_ctrl      o_ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_ready;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_ready <= 1'b1;
                    if (i_req_valid && r_ready) begin
                        r_state <= S_EXEC;
                        r_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state <= S_RESP;
                    r_valid <= 1'b1;
                end
                S_RESP: begin
                    if (i_rsp_ready) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b0;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b0;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_req_ready     = r_ready;
    assign o_rsp_valid     = r_valid;
    assign o_ctrl.capture  = i_req_valid && r_ready;
    assign o_ctrl.execute  = (r_state == S_EXEC);

endmodule

`default_nettype wire

// ----- rtl/drba_dp.sv -----
// datapath for the descriptor ring: pointers, allocator, slot memory, result
// driven by t_ctrl commands from drba_ctrl; uses drba_pkg
`default_nettype none

module drba_dp
    import drba_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ctrl                i_ctrl,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                 i_cmd,
    input  wire logic [DATA_W-1:0]    i_length,
    input  wire logic [DATA_W-1:0]    i_max_count,
    output t_status                   o_status,
    output logic [DATA_W-1:0]         o_buffer_offset,
    output logic [DATA_W-1:0]         o_buffer_length,
    output logic                      o_alloc_wrapped
);

    logic [DATA_W-1:0]   r_base;
    logic [DATA_W-1:0]   r_size;
    logic [IDX_W-1:0]    r_head;
    logic [IDX_W-1:0]    r_tail;
    logic [DATA_W-1:0]   r_alloc;

    logic                r_cmd;
    logic [DATA_W-1:0]   r_len;
    logic [DATA_W-1:0]   r_cnt;

    logic [2*DATA_W-1:0] r_mem [RING_SLOTS];
    logic [2*DATA_W-1:0] r_rd;

    t_status             r_status;
    logic [DATA_W-1:0]   r_boff;
    logic [DATA_W-1:0]   r_blen;
    logic                r_wrap;

    logic [IDX_W-1:0]    tail_nxt;
    logic                full;
    logic                empty;
    logic [DATA_W:0]     alloc_sum;
    logic                ovf;
    logic [DATA_W-1:0]   start;
    logic [DATA_W-1:0]   enq_off;
    logic [DATA_W-1:0]   slot_off;
    logic [DATA_W-1:0]   slot_len;
    logic                partial;

    logic                n_we;
    logic [IDX_W-1:0]    n_waddr;
    logic [2*DATA_W-1:0] n_wdata;
    t_status             n_status;
    logic [DATA_W-1:0]   n_boff;
    logic [DATA_W-1:0]   n_blen;
    logic                n_wrap;
    logic [IDX_W-1:0]    n_head;
    logic [IDX_W-1:0]    n_tail;
    logic [DATA_W-1:0]   n_alloc;

    assign tail_nxt  = r_tail + 1'b1;
    assign full      = (tail_nxt == r_head);
    assign empty     = (r_head == r_tail);
    assign alloc_sum = {1'b0, r_alloc} + {1'b0, r_len};
    assign ovf       = alloc_sum > {1'b0, r_size};
    assign start     = ovf ? '0 : r_alloc;
    assign enq_off   = r_base + start;
    assign slot_off  = r_rd[DATA_W-1:0];
    assign slot_len  = r_rd[2*DATA_W-1:DATA_W];
    assign partial   = (r_cnt != '0) && (r_cnt < slot_len);

    always_comb begin
        n_we     = 1'b0;
        n_waddr  = r_head;
        n_wdata  = '0;
        n_status = ST_OK;
        n_boff   = '0;
        n_blen   = '0;
        n_wrap   = 1'b0;
        n_head   = r_head;
        n_tail   = r_tail;
        n_alloc  = r_alloc;
        if (r_cmd == CMD_ENQ) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_boff  = enq_off;
                n_wrap  = ovf;
                n_alloc = start + r_len;
                n_we    = 1'b1;
                n_waddr = r_tail;
                n_wdata = {r_len, enq_off};
                n_tail  = tail_nxt;
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_boff  = slot_off;
                n_we    = 1'b1;
                n_waddr = r_head;
                if (partial) begin
                    n_blen  = r_cnt;
                    n_wdata = {slot_len - r_cnt, slot_off + r_cnt};
                end else begin
                    n_blen  = slot_len;
                    n_wdata = '0;
                    n_head  = r_head + 1'b1;
                end
            end
        end
    end

    // config and pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_size  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_alloc <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_BASE: r_base <= i_cfg_wdata;
                    CFG_SIZE: r_size <= i_cfg_wdata;
                    default:  r_base <= r_base;
                endcase
            end
            if (i_ctrl.execute) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_alloc <= n_alloc;
            end
        end
    end

    // request capture and result registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd <= i_cmd;
            r_len <= i_length;
            r_cnt <= i_max_count;
        end
        if (i_ctrl.execute) begin
            r_status <= n_status;
            r_boff   <= n_boff;
            r_blen   <= n_blen;
            r_wrap   <= n_wrap;
        end
    end

    // slot memory, head slot read every cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.execute && n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_rd <= r_mem[r_head];
    end

    assign o_status        = r_status;
    assign o_buffer_offset = r_boff;
    assign o_buffer_length = r_blen;
    assign o_alloc_wrapped = r_wrap;

endmodule

`default_nettype wire

// ----- rtl/descriptor_ring_with_bump_alloc.sv -----
// top level of the descriptor ring with bump allocator
// joins drba_ctrl and drba_dp; uses drba_pkg
//
// channel   direction  contents
// s_axis    in         tuser: cmd; tdata: length, max_count
// m_axis    out        tdata: status, buffer_offset, buffer_length, alloc_wrapped
// cfg       in         i_cfg_we, i_cfg_addr, i_cfg_wdata
//
// each request is accepted, executed and responded to before the next is taken; head slot read is registered
// the response register holds until m_axis_tready, no new request meanwhile
// synchronous active-low reset clears pointers, allocator and config
// slot memory is not cleared; only written slots are ever read
`default_nettype none

module descriptor_ring_with_bump_alloc
    import drba_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [63:0]          s_axis_tdata,  // length[31:0], max_count[63:32]
    input  wire logic                 s_axis_tuser,  // cmd[0]
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [71:0]               m_axis_tdata,  // status[1:0], buffer_offset[33:2],
                                                     // buffer_length[65:34], alloc_wrapped[66]
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [DATA_W-1:0]    i_cfg_wdata
);

    t_ctrl             ctrl;
    t_status           status;
    logic [DATA_W-1:0] boff;
    logic [DATA_W-1:0] blen;
    logic              wrap;

    drba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .o_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .o_ctrl      (ctrl)
    );

    drba_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (s_axis_tuser),
        .i_length        (s_axis_tdata[31:0]),
        .i_max_count     (s_axis_tdata[63:32]),
        .o_status        (status),
        .o_buffer_offset (boff),
        .o_buffer_length (blen),
        .o_alloc_wrapped (wrap)
    );

    assign m_axis_tdata = {5'b0, wrap, blen, boff, status};

endmodule

`default_nettype wire

// ----- verif/tb_descriptor_ring_with_bump_alloc.sv -----
// self-checking testbench for descriptor_ring_with_bump_alloc
// directed table then random enqueue/dequeue bursts, checked against an in-bench ring model
// depends on rtl/drba_pkg.sv and rtl/descriptor_ring_with_bump_alloc.sv
`timescale 1ns / 1ps

module tb_descriptor_ring_with_bump_alloc
    import drba_pkg::*;
();

    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int STALL_LIMIT   = 1000;
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] length;
        logic              wrapped;
    } t_ring_result;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic                 cmd;
        logic [DATA_W-1:0]    a;
        logic [DATA_W-1:0]    b;
        bit                   typed;
        t_ring_result         res;
    } t_step_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;   // length[31:0], max_count[63:32]
    logic                 s_axis_tuser;   // cmd[0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [71:0]          m_axis_tdata;   // status[1:0], buffer_offset[33:2],
                                          // buffer_length[65:34], alloc_wrapped[66]
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [DATA_W-1:0]    i_cfg_wdata;

    descriptor_ring_with_bump_alloc dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // ring model state
    logic [IDX_W-1:0]  rm_head;
    logic [IDX_W-1:0]  rm_tail;
    logic [DATA_W-1:0] rm_alloc;
    logic [DATA_W-1:0] rm_base;
    logic [DATA_W-1:0] rm_size;
    logic [DATA_W-1:0] rm_slot_off [RING_SLOTS];
    logic [DATA_W-1:0] rm_slot_len [RING_SLOTS];

    t_ring_result      pending_results [$];
    t_step_row         dir_rows [$];

    logic              req_typed;
    t_ring_result      req_typed_res;
    t_ring_result      mon_pred;
    t_ring_result      mon_got;
    logic              no_stall;

    int err_count;
    int n_enq, n_deq, n_res, n_full, n_empty, n_wrap, n_partial, n_cfg;
    int stall_cycles;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_ring_result ring_step(logic cmd, logic [DATA_W-1:0] len,
                                               logic [DATA_W-1:0] cnt);
        t_ring_result     r;
        logic [IDX_W-1:0] nxt;
        logic [DATA_W:0]  need;
        logic [DATA_W-1:0] so, sl;
        r.status  = ST_OK;
        r.offset  = '0;
        r.length  = '0;
        r.wrapped = 1'b0;
        if (cmd == CMD_ENQ) begin
            nxt = rm_tail + 1'b1;
            if (nxt == rm_head) begin
                r.status = ST_FULL;
            end else begin
                need = {1'b0, rm_alloc} + {1'b0, len};
                if (need > {1'b0, rm_size}) begin
                    rm_alloc  = '0;
                    r.wrapped = 1'b1;
                end
                r.offset = rm_base + rm_alloc;
                rm_alloc = rm_alloc + len;
                rm_slot_off[rm_tail] = r.offset;
                rm_slot_len[rm_tail] = len;
                rm_tail = nxt;
            end
        end else begin
            if (rm_head == rm_tail) begin
                r.status = ST_EMPTY;
            end else begin
                so = rm_slot_off[rm_head];
                sl = rm_slot_len[rm_head];
                r.offset = so;
                if (cnt != '0 && cnt < sl) begin
                    r.length = cnt;
                    rm_slot_off[rm_head] = so + cnt;
                    rm_slot_len[rm_head] = sl - cnt;
                    n_partial++;
                end else begin
                    r.length = sl;
                    rm_slot_off[rm_head] = '0;
                    rm_slot_len[rm_head] = '0;
                    rm_head = rm_head + 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic void add_req(logic cmd, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        t_step_row row;
        row = '{default: '0};
        row.cmd = cmd;
        row.a   = a;
        row.b   = b;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(logic cmd, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                      t_status st, logic [DATA_W-1:0] off,
                                      logic [DATA_W-1:0] blen, logic wr);
        t_step_row row;
        row = '{default: '0};
        row.cmd         = cmd;
        row.a           = a;
        row.b           = b;
        row.typed       = 1'b1;
        row.res.status  = st;
        row.res.offset  = off;
        row.res.length  = blen;
        row.res.wrapped = wr;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        t_step_row row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.a       = val;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [DATA_W-1:0] pick_length();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return $urandom_range(1, 32);
            3:       return rm_size >> $urandom_range(0, 8);
            4:       return $urandom_range(1, 4096);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0, 1, 2: return '0;
            3:       return $urandom_range(1, 16);
            4:       return $urandom_range(1, 4096);
            5:       return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_cfg_value();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return $urandom_range(1, 4096);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(logic cmd, logic [DATA_W-1:0] len, logic [DATA_W-1:0] cnt,
                                logic typed, t_ring_result typed_res);
        @(negedge i_clk);
        if (!no_stall && $urandom_range(0, 99) < 6) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        req_typed     = typed;
        req_typed_res = typed_res;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {cnt, len};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic settle_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_BASE) rm_base = val;
        else                 rm_size = val;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= no_stall || ($urandom_range(0, 99) >= 6);
    end

    // request capture, response check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                mon_pred = ring_step(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
                if (req_typed) mon_pred = req_typed_res;
                if (s_axis_tuser == CMD_ENQ) n_enq++;
                else                         n_deq++;
                if (mon_pred.status == ST_FULL)  n_full++;
                if (mon_pred.status == ST_EMPTY) n_empty++;
                if (mon_pred.wrapped)            n_wrap++;
                pending_results.push_back(mon_pred);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_res++;
                mon_got.status  = t_status'(m_axis_tdata[1:0]);
                mon_got.offset  = m_axis_tdata[33:2];
                mon_got.length  = m_axis_tdata[65:34];
                mon_got.wrapped = m_axis_tdata[66];
                if (pending_results.size() == 0) begin
                    $error("response with no request pending: %h", m_axis_tdata);
                    err_count++;
                end else begin
                    mon_pred = pending_results.pop_front();
                    if (mon_got.status != mon_pred.status) begin
                        $error("status mismatch: expected %0d actual %0d",
                               mon_pred.status, mon_got.status);
                        err_count++;
                    end
                    if (mon_got.offset != mon_pred.offset) begin
                        $error("buffer_offset mismatch: expected %h actual %h",
                               mon_pred.offset, mon_got.offset);
                        err_count++;
                    end
                    if (mon_got.length != mon_pred.length) begin
                        $error("buffer_length mismatch: expected %h actual %h",
                               mon_pred.length, mon_got.length);
                        err_count++;
                    end
                    if (mon_got.wrapped != mon_pred.wrapped) begin
                        $error("alloc_wrapped mismatch: expected %0d actual %0d",
                               mon_pred.wrapped, mon_got.wrapped);
                        err_count++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin
        t_ring_result none;
        t_step_row    row;
        int           done;
        int           burst;
        int           mode;
        logic         cmd;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        req_typed     = 1'b0;
        req_typed_res = '0;
        no_stall      = 1'b0;
        none          = '0;
        err_count     = 0;
        stall_cycles  = 0;
        n_enq = 0; n_deq = 0; n_res = 0; n_full = 0; n_empty = 0;
        n_wrap = 0; n_partial = 0; n_cfg = 0;
        rm_head  = '0;
        rm_tail  = '0;
        rm_alloc = '0;
        rm_base  = '0;
        rm_size  = '0;
        for (int i = 0; i < RING_SLOTS; i++) begin
            rm_slot_off[i] = '0;
            rm_slot_len[i] = '0;
        end

        // reset config: base 0, size 0
        add_typed(CMD_DEQ, '0, '0, ST_EMPTY, '0, '0, 1'b0);
        add_typed(CMD_DEQ, ALL_ONES, ALL_ONES, ST_EMPTY, '0, '0, 1'b0);
        add_typed(CMD_ENQ, '0, '0, ST_OK, '0, '0, 1'b0);
        add_typed(CMD_ENQ, ALL_ONES, '0, ST_OK, '0, '0, 1'b1);
        add_req(CMD_ENQ, 32'd1, ALL_ONES);
        add_req(CMD_DEQ, ALL_ONES, '0);
        add_req(CMD_DEQ, '0, 32'd1);
        add_req(CMD_DEQ, '0, 32'hFFFF_FFFE);
        add_req(CMD_DEQ, '0, ALL_ONES);
        add_typed(CMD_DEQ, '0, '0, ST_EMPTY, '0, '0, 1'b0);
        // offsets wrap past the top of the region, tiny area
        add_cfg(CFG_BASE, 32'hFFFF_FFF0);
        add_cfg(CFG_SIZE, 32'd16);
        add_req(CMD_ENQ, 32'd16, '0);
        add_req(CMD_ENQ, 32'd1, '0);
        add_req(CMD_ENQ, '0, '0);
        add_req(CMD_ENQ, 32'd15, '0);
        add_req(CMD_DEQ, '0, 32'd5);
        add_req(CMD_DEQ, '0, 32'd11);
        add_req(CMD_DEQ, '0, '0);
        add_req(CMD_DEQ, '0, 32'd1);
        add_req(CMD_DEQ, '0, ALL_ONES);
        add_typed(CMD_DEQ, '0, '0, ST_EMPTY, '0, '0, 1'b0);
        // full-size area
        add_cfg(CFG_BASE, '0);
        add_cfg(CFG_SIZE, ALL_ONES);
        add_req(CMD_ENQ, ALL_ONES, '0);
        add_req(CMD_ENQ, 32'd1, '0);
        add_req(CMD_DEQ, '0, 32'h8000_0000);
        add_req(CMD_DEQ, '0, '0);
        add_req(CMD_DEQ, '0, '0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                settle_idle();
                cfg_write(row.cfg_idx, row.a);
            end else begin
                send_request(row.cmd, row.a, row.b, row.typed, row.res);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle_idle();
            if (ph == 0) begin
                cfg_write(CFG_BASE, '0);
                cfg_write(CFG_SIZE, '0);
            end else if (ph == 1) begin
                cfg_write(CFG_BASE, ALL_ONES);
                cfg_write(CFG_SIZE, ALL_ONES);
            end else begin
                cfg_write(CFG_BASE, pick_cfg_value());
                cfg_write(CFG_SIZE, pick_cfg_value());
            end
            no_stall = (ph == 3);
            done = 0;
            while (done < PHASE_ITEMS) begin
                mode  = $urandom_range(0, 9);
                burst = (mode < 4) ? $urandom_range(40, 70) : $urandom_range(5, 25);
                for (int k = 0; k < burst; k++) begin
                    if (mode < 2)      cmd = CMD_ENQ;
                    else if (mode < 4) cmd = CMD_DEQ;
                    else               cmd = logic'($urandom_range(0, 1));
                    send_request(cmd, pick_length(), pick_count(), 1'b0, none);
                end
                done += burst;
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d responses never arrived", pending_results.size());
            err_count++;
        end

        $display("covered %0d enqueues, %0d dequeues, %0d responses, %0d register writes",
                 n_enq, n_deq, n_res, n_cfg);
        $display("ring full %0d, ring empty %0d, allocator wraps %0d, partial dequeues %0d",
                 n_full, n_empty, n_wrap, n_partial);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
